@@ src/msie_pkg.sv @@
package msie_pkg;

    // Register file geometry.
    localparam int REGISTER_COUNT = 32;
    localparam int REG_AW = $clog2(REGISTER_COUNT);

    // Widths of the data path.
    localparam int XLEN = 32;

    // Reset values of the configuration registers.
    localparam logic [XLEN-1:0] START_ADDRESS_RST = 32'h0040_0000;
    localparam logic [XLEN-1:0] GP_INIT_RST = 32'h1000_8000;
    localparam logic [XLEN-1:0] SP_INIT_RST = 32'h1001_0000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_GP = 2'd1;
    localparam logic [1:0] CFG_SP = 2'd2;

    // Registers with a fixed role: zero, gp and sp (restart values of their own), and the jal link.
    localparam logic [REG_AW-1:0] REG_X0 = 5'd0;
    localparam logic [REG_AW-1:0] REG_GP = 5'd28;
    localparam logic [REG_AW-1:0] REG_SP = 5'd29;
    localparam logic [REG_AW-1:0] REG_RA = 5'd31;

    // Input action codes.
    localparam logic [1:0] ACT_EXEC = 2'd0;
    localparam logic [1:0] ACT_LOAD = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Memory request codes.
    localparam logic [1:0] MREQ_NONE = 2'd0;
    localparam logic [1:0] MREQ_LOAD = 2'd1;
    localparam logic [1:0] MREQ_STORE = 2'd2;

    // Opcodes.
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_J = 6'h02;
    localparam logic [5:0] OPC_JAL = 6'h03;
    localparam logic [5:0] OPC_BEQ = 6'h04;
    localparam logic [5:0] OPC_BNE = 6'h05;
    localparam logic [5:0] OPC_ADDIU = 6'h09;
    localparam logic [5:0] OPC_ANDI = 6'h0c;
    localparam logic [5:0] OPC_LUI = 6'h0f;
    localparam logic [5:0] OPC_TRAP = 6'h1a;
    localparam logic [5:0] OPC_LW = 6'h23;
    localparam logic [5:0] OPC_SW = 6'h2b;

    // Function codes of the special opcode.
    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRA = 6'h03;
    localparam logic [5:0] FN_JR = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV = 6'h1A;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT = 6'h2A;

    // Trap codes that leave the machine running.
    localparam logic [3:0] TRAP_PRINT_INT = 4'h0;
    localparam logic [3:0] TRAP_PRINT_STR = 4'h1;
    localparam logic [3:0] TRAP_READ_INT = 4'h5;

    // Top nibble of the jump region.
    localparam logic [XLEN-1:0] JUMP_REGION_MASK = 32'hf000_0000;

    // Operation class found by the front end.
    typedef enum logic [4:0] {
        OP_SLL, OP_SRA, OP_JR, OP_MFHI, OP_MFLO, OP_MULT, OP_DIV, OP_ADDU,
        OP_SUBU, OP_SLT, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_ANDI,
        OP_LUI, OP_TRAP_NOP, OP_TRAP_HALT, OP_LW, OP_SW, OP_UNKNOWN
    } t_op;

    // One classified input word.
    typedef struct packed {
        logic [1:0] action;
        t_op op;
        logic [REG_AW-1:0] rs;
        logic [REG_AW-1:0] rt;
        logic [REG_AW-1:0] rd;
        logic [4:0] shamt;
        logic [15:0] imm;
        logic [25:0] jfield;
        logic [XLEN-1:0] load_data;
    } t_item;

    // Head of the queue between front and back.
    typedef struct packed {
        logic valid;
        t_item item;
    } t_head;

    // One result word.
    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic [1:0] mem_request;
        logic [XLEN-1:0] mem_address;
        logic [XLEN-1:0] store_value;
        logic halted;
        logic unknown_instruction;
    } t_res;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MUL, S_DIV, S_DFIX
    } t_state;

    // Maps an instruction word to its operation class.
    function automatic t_op classify(input logic [XLEN-1:0] instr);
        t_op op;
        op = OP_UNKNOWN;
        case (instr[31:26])
            OPC_SPECIAL: begin
                case (instr[5:0])
                    FN_SLL: op = OP_SLL;
                    FN_SRA: op = OP_SRA;
                    FN_JR: op = OP_JR;
                    FN_MFHI: op = OP_MFHI;
                    FN_MFLO: op = OP_MFLO;
                    FN_MULT: op = OP_MULT;
                    FN_DIV: op = OP_DIV;
                    FN_ADDU: op = OP_ADDU;
                    FN_SUBU: op = OP_SUBU;
                    FN_SLT: op = OP_SLT;
                    default: op = OP_UNKNOWN;
                endcase
            end
            OPC_J: op = OP_J;
            OPC_JAL: op = OP_JAL;
            OPC_BEQ: op = OP_BEQ;
            OPC_BNE: op = OP_BNE;
            OPC_ADDIU: op = OP_ADDIU;
            OPC_ANDI: op = OP_ANDI;
            OPC_LUI: op = OP_LUI;
            OPC_TRAP: begin
                if (instr[3:0] inside {TRAP_PRINT_INT, TRAP_PRINT_STR, TRAP_READ_INT}) begin
                    op = OP_TRAP_NOP;
                end else begin
                    op = OP_TRAP_HALT;
                end
            end
            OPC_LW: op = OP_LW;
            OPC_SW: op = OP_SW;
            default: op = OP_UNKNOWN;
        endcase
        return op;
    endfunction

endpackage

@@ src/msie_ram.sv @@
module msie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/msie_front.sv @@
module msie_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [1:0]               i_action,
    input  logic [31:0]              i_instr_word,
    input  logic [31:0]              i_load_data,
    output msie_pkg::t_head          o_head,
    input  logic                     i_pop
);

    msie_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    msie_pkg::t_item w_item;
    logic            w_push;
    logic            w_pop;

    // Split the word into its fields and classify it.
    always_comb begin
        w_item.action = i_action;
        w_item.op = msie_pkg::classify(i_instr_word);
        w_item.rs = i_instr_word[25:21];
        w_item.rt = i_instr_word[20:16];
        w_item.rd = i_instr_word[15:11];
        w_item.shamt = i_instr_word[10:6];
        w_item.imm = i_instr_word[15:0];
        w_item.jfield = i_instr_word[25:0];
        w_item.load_data = i_load_data;
    end

    assign o_full = (r_cnt == 2'd2);
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item = r_q[r_rp];

    // Two-entry queue toward the back end.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ src/msie_back.sv @@
module msie_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  msie_pkg::t_head i_head,
    output logic            o_pop,
    output logic            o_empty,
    input  logic            i_res_pop,
    output msie_pkg::t_res  o_res
);

    localparam int AW = msie_pkg::REG_AW;
    localparam int RC = msie_pkg::REGISTER_COUNT;

    // Configuration and restart snapshots.
    logic [31:0] r_cfg_start, r_cfg_gp, r_cfg_sp;
    logic [31:0] r_gp0, r_sp0;

    // Architectural state.
    logic [RC-1:0] r_valid;
    logic [31:0]   r_pc, n_pc;
    logic [31:0]   r_hi, n_hi;
    logic [31:0]   r_lo, n_lo;
    logic [AW-1:0] r_ld_tgt, n_ld_tgt;
    logic          r_ld_wait, n_ld_wait;
    logic          r_halt, n_halt;
    logic          w_restart;

    // Sequencer.
    msie_pkg::t_state r_state, n_state;
    msie_pkg::t_item  r_it;
    logic             r_va, r_vb;
    logic [63:0]      r_prod, n_prod;
    logic signed [63:0] w_prod;

    // Divider.
    logic [31:0] r_dq, n_dq;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dv, n_dv;
    logic [4:0]  r_dcnt, n_dcnt;
    logic        r_qneg, n_qneg;
    logic        r_rneg, n_rneg;
    logic [32:0] w_rsh, w_diff;

    // Register file ports.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [31:0]   w_ra, w_rb;
    logic [31:0]   w_vs, w_vt;

    // Result queue.
    msie_pkg::t_res r_oq [2];
    logic           r_owp, r_orp;
    logic [1:0]     r_ocnt;
    logic           w_opush, w_opop, w_ofull;
    msie_pkg::t_res w_res;

    // Decode helpers.
    logic [31:0] w_simm, w_pc4, w_jt, w_bt;

    msie_ram #(.WIDTH(32), .DEPTH(RC)) u_ram_a (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(i_head.item.rs), .o_rdata(w_ra)
    );

    msie_ram #(.WIDTH(32), .DEPTH(RC)) u_ram_b (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(i_head.item.rt), .o_rdata(w_rb)
    );

    // Operand values; an entry not written since restart holds its restart value.
    function automatic logic [31:0] operand(input logic [AW-1:0] idx, input logic vld,
                                            input logic [31:0] ram, input logic [31:0] gp,
                                            input logic [31:0] sp);
        logic [31:0] v;
        if (idx == msie_pkg::REG_X0) begin
            v = '0;
        end else if (vld) begin
            v = ram;
        end else if (idx == msie_pkg::REG_GP) begin
            v = gp;
        end else if (idx == msie_pkg::REG_SP) begin
            v = sp;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    assign w_vs = operand(r_it.rs, r_va, w_ra, r_gp0, r_sp0);
    assign w_vt = operand(r_it.rt, r_vb, w_rb, r_gp0, r_sp0);

    // Signed 32 by 32 product, kept at its full 64 bits.
    assign w_prod = $signed(w_vs) * $signed(w_vt);

    assign w_simm = {{16{r_it.imm[15]}}, r_it.imm};
    assign w_pc4 = r_pc + 32'd4;
    assign w_jt = (w_pc4 & msie_pkg::JUMP_REGION_MASK) | {4'b0, r_it.jfield, 2'b00};
    assign w_bt = w_pc4 + {w_simm[29:0], 2'b00};

    // One restoring division step.
    assign w_rsh = {r_rem, r_dq[31]};
    assign w_diff = w_rsh - {1'b0, r_dv};

    assign w_ofull = (r_ocnt == 2'd2);
    assign o_empty = (r_ocnt == 2'd0);
    assign w_opop = i_res_pop && !o_empty;
    assign o_res = r_oq[r_orp];
    assign o_pop = (r_state == msie_pkg::S_IDLE) && i_head.valid && !w_ofull;

    // Next state, register writes and results.
    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        n_hi = r_hi;
        n_lo = r_lo;
        n_ld_tgt = r_ld_tgt;
        n_ld_wait = r_ld_wait;
        n_halt = r_halt;
        n_prod = r_prod;
        n_dq = r_dq;
        n_rem = r_rem;
        n_dv = r_dv;
        n_dcnt = r_dcnt;
        n_qneg = r_qneg;
        n_rneg = r_rneg;
        w_restart = 1'b0;
        w_we = 1'b0;
        w_waddr = r_it.rd;
        w_wdata = '0;
        w_opush = 1'b0;
        w_res = '0;
        case (r_state)
            msie_pkg::S_IDLE: begin
                if (o_pop) begin
                    n_state = msie_pkg::S_EXEC;
                end
            end
            msie_pkg::S_EXEC: begin
                n_state = msie_pkg::S_IDLE;
                w_opush = 1'b1;
                if (r_it.action == msie_pkg::ACT_RESTART) begin
                    w_restart = 1'b1;
                    n_pc = r_cfg_start;
                    n_hi = '0;
                    n_lo = '0;
                    n_ld_tgt = '0;
                    n_ld_wait = 1'b0;
                    n_halt = 1'b0;
                end else if (r_it.action == msie_pkg::ACT_LOAD) begin
                    if (r_ld_wait) begin
                        w_we = 1'b1;
                        w_waddr = r_ld_tgt;
                        w_wdata = r_it.load_data;
                        n_ld_wait = 1'b0;
                    end
                end else if (r_it.action == msie_pkg::ACT_EXEC && !r_halt && !r_ld_wait) begin
                    n_pc = w_pc4;
                    case (r_it.op)
                        msie_pkg::OP_SLL: begin
                            w_we = 1'b1;
                            w_wdata = w_vt << r_it.shamt;
                        end
                        msie_pkg::OP_SRA: begin
                            w_we = 1'b1;
                            w_wdata = $unsigned($signed(w_vt) >>> r_it.shamt);
                        end
                        msie_pkg::OP_JR: n_pc = w_vs;
                        msie_pkg::OP_MFHI: begin
                            w_we = 1'b1;
                            w_wdata = r_hi;
                        end
                        msie_pkg::OP_MFLO: begin
                            w_we = 1'b1;
                            w_wdata = r_lo;
                        end
                        msie_pkg::OP_MULT: begin
                            n_prod = $unsigned(w_prod);
                            w_opush = 1'b0;
                            n_state = msie_pkg::S_MUL;
                        end
                        msie_pkg::OP_DIV: begin
                            if (w_vt == '0) begin
                                n_hi = '0;
                                n_lo = '0;
                            end else begin
                                n_dq = w_vs[31] ? (32'd0 - w_vs) : w_vs;
                                n_dv = w_vt[31] ? (32'd0 - w_vt) : w_vt;
                                n_rem = '0;
                                n_dcnt = '0;
                                n_qneg = w_vs[31] ^ w_vt[31];
                                n_rneg = w_vs[31];
                                w_opush = 1'b0;
                                n_state = msie_pkg::S_DIV;
                            end
                        end
                        msie_pkg::OP_ADDU: begin
                            w_we = 1'b1;
                            w_wdata = w_vs + w_vt;
                        end
                        msie_pkg::OP_SUBU: begin
                            w_we = 1'b1;
                            w_wdata = w_vs - w_vt;
                        end
                        msie_pkg::OP_SLT: begin
                            w_we = 1'b1;
                            w_wdata = {31'd0, ($signed(w_vs) < $signed(w_vt))};
                        end
                        msie_pkg::OP_J: n_pc = w_jt;
                        msie_pkg::OP_JAL: begin
                            w_we = 1'b1;
                            w_waddr = msie_pkg::REG_RA;
                            w_wdata = w_pc4;
                            n_pc = w_jt;
                        end
                        msie_pkg::OP_BEQ: begin
                            if (w_vs == w_vt) begin
                                n_pc = w_bt;
                            end
                        end
                        msie_pkg::OP_BNE: begin
                            if (w_vs != w_vt) begin
                                n_pc = w_bt;
                            end
                        end
                        msie_pkg::OP_ADDIU: begin
                            w_we = 1'b1;
                            w_waddr = r_it.rt;
                            w_wdata = w_vs + w_simm;
                        end
                        msie_pkg::OP_ANDI: begin
                            w_we = 1'b1;
                            w_waddr = r_it.rt;
                            w_wdata = w_vs & {16'd0, r_it.imm};
                        end
                        msie_pkg::OP_LUI: begin
                            w_we = 1'b1;
                            w_waddr = r_it.rt;
                            w_wdata = {r_it.imm, 16'd0};
                        end
                        msie_pkg::OP_TRAP_NOP: ;
                        msie_pkg::OP_TRAP_HALT: n_halt = 1'b1;
                        msie_pkg::OP_LW: begin
                            w_res.mem_request = msie_pkg::MREQ_LOAD;
                            w_res.mem_address = w_vs + w_simm;
                            n_ld_tgt = r_it.rt;
                            n_ld_wait = 1'b1;
                        end
                        msie_pkg::OP_SW: begin
                            w_res.mem_request = msie_pkg::MREQ_STORE;
                            w_res.mem_address = w_vs + w_simm;
                            w_res.store_value = w_vt;
                        end
                        default: w_res.unknown_instruction = 1'b1;
                    endcase
                end
            end
            msie_pkg::S_MUL: begin
                n_hi = r_prod[63:32];
                n_lo = r_prod[31:0];
                w_opush = 1'b1;
                n_state = msie_pkg::S_IDLE;
            end
            msie_pkg::S_DIV: begin
                if (!w_diff[32]) begin
                    n_rem = w_diff[31:0];
                    n_dq = {r_dq[30:0], 1'b1};
                end else begin
                    n_rem = w_rsh[31:0];
                    n_dq = {r_dq[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_state = msie_pkg::S_DFIX;
                end
            end
            msie_pkg::S_DFIX: begin
                n_lo = r_qneg ? (32'd0 - r_dq) : r_dq;
                n_hi = r_rneg ? (32'd0 - r_rem) : r_rem;
                w_opush = 1'b1;
                n_state = msie_pkg::S_IDLE;
            end
            default: n_state = msie_pkg::S_IDLE;
        endcase
        // Register zero is never written.
        if (w_waddr == msie_pkg::REG_X0) begin
            w_we = 1'b0;
        end
        w_res.next_pc = n_pc;
        w_res.halted = n_halt;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= msie_pkg::START_ADDRESS_RST;
            r_cfg_gp <= msie_pkg::GP_INIT_RST;
            r_cfg_sp <= msie_pkg::SP_INIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                msie_pkg::CFG_START: r_cfg_start <= i_cfg_data;
                msie_pkg::CFG_GP: r_cfg_gp <= i_cfg_data;
                msie_pkg::CFG_SP: r_cfg_sp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Architectural state and sequencer.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it <= i_head.item;
            r_va <= r_valid[i_head.item.rs];
            r_vb <= r_valid[i_head.item.rt];
        end
        r_prod <= n_prod;
        r_dq <= n_dq;
        r_rem <= n_rem;
        r_dv <= n_dv;
        r_dcnt <= n_dcnt;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
        if (!i_rst_n) begin
            r_state <= msie_pkg::S_IDLE;
            r_valid <= '0;
            r_gp0 <= msie_pkg::GP_INIT_RST;
            r_sp0 <= msie_pkg::SP_INIT_RST;
            r_pc <= msie_pkg::START_ADDRESS_RST;
            r_hi <= '0;
            r_lo <= '0;
            r_ld_tgt <= '0;
            r_ld_wait <= 1'b0;
            r_halt <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
            r_hi <= n_hi;
            r_lo <= n_lo;
            r_ld_tgt <= n_ld_tgt;
            r_ld_wait <= n_ld_wait;
            r_halt <= n_halt;
            if (w_restart) begin
                r_valid <= '0;
                r_gp0 <= r_cfg_gp;
                r_sp0 <= r_cfg_sp;
            end else if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    // Two-entry result queue.
    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_oq[r_owp] <= w_res;
        end
        if (!i_rst_n) begin
            r_owp <= 1'b0;
            r_orp <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_opush) begin
                r_owp <= !r_owp;
            end
            if (w_opop) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, w_opush} - {1'b0, w_opop};
        end
    end

endmodule

@@ src/mips_subset_instruction_executor.sv @@
// Executes one word per input item from a MIPS32 subset (sll, sra, jr, mfhi, mflo,
// mult, div, addu, subu, slt, j, jal, beq, bne, addiu, andi, lui, lw, sw, trap).
// Items enter a two-entry queue after classification; the back end takes one item
// at a time and returns one result word per item in order through a two-entry
// result queue. In the back end most items see a register file read, then execute;
// mult adds a hi/lo write step; a div by nonzero runs the divider, one quotient bit
// per cycle, then a sign fix-up. Action 1 returns load data for a pending lw, action 2
// restarts the machine using the start address and gp/sp values last written on
// the configuration port; configuration takes effect only at restart.
module mips_subset_instruction_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_load_data,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_next_pc,
    output logic [1:0]  o_mem_request,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_store_value,
    output logic        o_halted,
    output logic        o_unknown_instruction,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    msie_pkg::t_head w_head;
    msie_pkg::t_res  w_res;
    logic            w_hpop;

    msie_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_action(i_action), .i_instr_word(i_instr_word), .i_load_data(i_load_data),
        .o_head(w_head), .i_pop(w_hpop)
    );

    msie_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_head(w_head), .o_pop(w_hpop), .o_empty(empty),
        .i_res_pop(pop), .o_res(w_res)
    );

    // Result word fields.
    assign o_next_pc = w_res.next_pc;
    assign o_mem_request = w_res.mem_request;
    assign o_mem_address = w_res.mem_address;
    assign o_store_value = w_res.store_value;
    assign o_halted = w_res.halted;
    assign o_unknown_instruction = w_res.unknown_instruction;

endmodule

@@ src/msie_checker.sv @@
module msie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_next_pc,
    input logic [1:0]  o_mem_request,
    input logic [31:0] o_mem_address,
    input logic [31:0] o_store_value,
    input logic        o_unknown_instruction
);

    // Reset leaves no result word waiting.
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // The next pc of a waiting word holds until the word is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_next_pc))
        else $error("waiting result word changed");

    // Only stores carry a store value.
    a_sval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_mem_request != msie_pkg::MREQ_STORE |-> o_store_value == '0)
        else $error("store value without store");

    // No address without a memory request.
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_mem_request == msie_pkg::MREQ_NONE |-> o_mem_address == '0)
        else $error("address without request");

    // An unknown word makes no memory request.
    a_unk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_unknown_instruction |-> o_mem_request == msie_pkg::MREQ_NONE)
        else $error("unknown word with memory request");

endmodule

bind mips_subset_instruction_executor msie_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop), .o_next_pc(o_next_pc),
    .o_mem_request(o_mem_request), .o_mem_address(o_mem_address),
    .o_store_value(o_store_value), .o_unknown_instruction(o_unknown_instruction)
);
